/* design/lpfp_pkg.sv */
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants for the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

   // Hard ceiling on the body length; the payload length field is 20 bits wide.
   localparam int unsigned BODY_LIMIT     = 1024 * 1024;
   localparam int unsigned FIELD_BODY_CAP = 1048581;
   localparam int unsigned LENGTH_CAP     =
      (BODY_LIMIT < FIELD_BODY_CAP) ? BODY_LIMIT : FIELD_BODY_CAP;

   // Body length covers type (2 bytes) and id (4 bytes).
   localparam int unsigned MIN_BODY     = 6;
   localparam int unsigned LENGTH_BYTES = 4;

   localparam int unsigned MAX_BODY_WIDTH = 21;
   localparam int unsigned TYPE_WIDTH     = 16;
   localparam int unsigned ID_WIDTH       = 32;
   localparam int unsigned PLEN_WIDTH     = 20;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register indexes (byte address is 4 * index)
   localparam logic [1:0] REG_MAX_BODY_LENGTH  = 2'd0;
   localparam logic [1:0] REG_VALID_TYPE_FIRST = 2'd1;
   localparam logic [1:0] REG_VALID_TYPE_LAST  = 2'd2;

   localparam logic [MAX_BODY_WIDTH-1:0] MAX_BODY_RESET    = 21'd1048576;
   localparam logic [TYPE_WIDTH-1:0]     TYPE_FIRST_RESET  = 16'd1;
   localparam logic [TYPE_WIDTH-1:0]     TYPE_LAST_RESET   = 16'd15;

   // Result kinds
   localparam logic [1:0] KIND_HEADER_BYTE = 2'd0;
   localparam logic [1:0] KIND_HEADER_DONE = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD     = 2'd2;
   localparam logic [1:0] KIND_FATAL       = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_TOO_SHORT = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

   typedef struct packed {
      logic [MAX_BODY_WIDTH-1:0] max_body_length;
      logic [TYPE_WIDTH-1:0]     valid_type_first;
      logic [TYPE_WIDTH-1:0]     valid_type_last;
   } cfg_type;

   typedef struct packed {
      logic [7:0] stream_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [TYPE_WIDTH-1:0] message_type;
      logic [ID_WIDTH-1:0]   message_id;
      logic [PLEN_WIDTH-1:0] payload_length;
      logic [7:0]            payload_data;
      logic                  frame_end;
      logic                  type_known;
      logic [1:0]            error_code;
   } rsp_payload_type;

endpackage

/* design/lpfp_stream_if.sv */
// ----------------------------------------------------------------------------
// lpfp_stream_if
// Valid/ready channel carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
interface lpfp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* design/lpfp_csr.sv */
// ----------------------------------------------------------------------------
// lpfp_csr
// APB-style register file for the parser limits and valid type range.
// ----------------------------------------------------------------------------
module lpfp_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lpfp_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [lpfp_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [lpfp_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready,
   output lpfp_pkg::cfg_type                      cfg
);

   lpfp_pkg::cfg_type cfg_ff;
   lpfp_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            lpfp_pkg::REG_MAX_BODY_LENGTH:
               cfg_in.max_body_length = csr_pwdata[lpfp_pkg::MAX_BODY_WIDTH-1:0];
            lpfp_pkg::REG_VALID_TYPE_FIRST:
               cfg_in.valid_type_first = csr_pwdata[lpfp_pkg::TYPE_WIDTH-1:0];
            lpfp_pkg::REG_VALID_TYPE_LAST:
               cfg_in.valid_type_last = csr_pwdata[lpfp_pkg::TYPE_WIDTH-1:0];
            default: ; // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         lpfp_pkg::REG_MAX_BODY_LENGTH:
            csr_prdata = lpfp_pkg::CSR_DATA_WIDTH'(cfg_ff.max_body_length);
         lpfp_pkg::REG_VALID_TYPE_FIRST:
            csr_prdata = lpfp_pkg::CSR_DATA_WIDTH'(cfg_ff.valid_type_first);
         lpfp_pkg::REG_VALID_TYPE_LAST:
            csr_prdata = lpfp_pkg::CSR_DATA_WIDTH'(cfg_ff.valid_type_last);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_body_length  <= lpfp_pkg::MAX_BODY_RESET;
         cfg_ff.valid_type_first <= lpfp_pkg::TYPE_FIRST_RESET;
         cfg_ff.valid_type_last  <= lpfp_pkg::TYPE_LAST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/lpfp_deframer.sv */
// ----------------------------------------------------------------------------
// lpfp_deframer
// Input byte register, header/payload state update and result register.
// ----------------------------------------------------------------------------
module lpfp_deframer (
   input  logic                  clock,
   input  logic                  reset,
   input  lpfp_pkg::cfg_type     cfg,
   lpfp_stream_if.sink           req_chan,
   lpfp_stream_if.source         rsp_chan
);

   // Header byte positions
   localparam logic [3:0] POS_LEN_LAST   = 4'd3;
   localparam logic [3:0] POS_TYPE_FIRST = 4'd4;
   localparam logic [3:0] POS_ID_FIRST   = 4'd6;
   localparam logic [3:0] POS_ID_LAST    = 4'd9;
   localparam logic [3:0] POS_PAYLOAD    = 4'd10;

   localparam int unsigned LW = lpfp_pkg::LENGTH_BYTES * 8;
   localparam int unsigned TW = lpfp_pkg::TYPE_WIDTH;
   localparam int unsigned IW = lpfp_pkg::ID_WIDTH;
   localparam int unsigned PW = lpfp_pkg::PLEN_WIDTH;
   localparam int unsigned MW = lpfp_pkg::MAX_BODY_WIDTH;

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // frame state
   logic [3:0]    pos_ff,   pos_in;
   logic [LW-9:0] len_ff,   len_in;    // low three bytes, shifted in order
   logic [TW-1:0] type_ff,  type_in;
   logic [IW-1:0] id_ff,    id_in;
   logic [PW-1:0] plen_ff,  plen_in;
   logic [PW-1:0] rem_ff,   rem_in;
   logic          fatal_ff, fatal_in;
   logic [1:0]    err_ff,   err_in;

   // result stage
   logic                      out_valid_ff;
   lpfp_pkg::rsp_payload_type out_ff;
   lpfp_pkg::rsp_payload_type result;

   logic          advance;
   logic [LW-1:0] len_word;
   logic [LW-1:0] len_less;
   logic [IW-1:0] id_word;
   logic [MW-1:0] eff_max;
   logic          too_short;
   logic          too_long;
   logic          type_ok;

   assign advance        = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | advance;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   assign len_word  = {len_ff, in_byte_ff};
   assign len_less  = len_word - LW'(lpfp_pkg::MIN_BODY);
   assign id_word   = {id_ff[IW-9:0], in_byte_ff};
   assign eff_max   = (cfg.max_body_length < MW'(lpfp_pkg::LENGTH_CAP)) ?
                      cfg.max_body_length : MW'(lpfp_pkg::LENGTH_CAP);
   assign too_short = len_word < LW'(lpfp_pkg::MIN_BODY);
   assign too_long  = len_word > LW'(eff_max);
   assign type_ok   = (type_ff >= cfg.valid_type_first) &&
                      (type_ff <= cfg.valid_type_last);

   always_comb begin
      pos_in   = pos_ff;
      len_in   = len_ff;
      type_in  = type_ff;
      id_in    = id_ff;
      plen_in  = plen_ff;
      rem_in   = rem_ff;
      fatal_in = fatal_ff;
      err_in   = err_ff;
      result   = '0;
      result.kind = lpfp_pkg::KIND_HEADER_BYTE;

      priority if (fatal_ff) begin
         result.kind       = lpfp_pkg::KIND_FATAL;
         result.error_code = err_ff;
      end else if (pos_ff < POS_TYPE_FIRST) begin
         len_in = len_word[LW-9:0];
         pos_in = pos_ff + 4'd1;
         if (pos_ff == POS_LEN_LAST) begin
            plen_in = len_less[PW-1:0];
            if (too_short || too_long) begin
               fatal_in          = 1'b1;
               err_in            = too_short ? lpfp_pkg::ERR_TOO_SHORT
                                             : lpfp_pkg::ERR_TOO_LONG;
               result.kind       = lpfp_pkg::KIND_FATAL;
               result.error_code = err_in;
            end
         end
      end else if (pos_ff < POS_ID_FIRST) begin
         type_in = {type_ff[TW-9:0], in_byte_ff};
         pos_in  = pos_ff + 4'd1;
      end else if (pos_ff < POS_PAYLOAD) begin
         id_in  = id_word;
         pos_in = pos_ff + 4'd1;
         if (pos_ff == POS_ID_LAST) begin
            result.kind           = lpfp_pkg::KIND_HEADER_DONE;
            result.message_type   = type_ff;
            result.message_id     = id_word;
            result.payload_length = plen_ff;
            rem_in                = plen_ff;
            if (plen_ff == '0) begin
               // header-only frame closes here
               result.frame_end  = 1'b1;
               result.type_known = type_ok;
               pos_in            = '0;
            end
         end
      end else begin
         result.kind           = lpfp_pkg::KIND_PAYLOAD;
         result.message_type   = type_ff;
         result.message_id     = id_ff;
         result.payload_length = plen_ff;
         result.payload_data   = in_byte_ff;
         if (rem_ff != '0) begin
            rem_in = rem_ff - PW'(1);
         end
         if (rem_ff <= PW'(1)) begin
            result.frame_end  = 1'b1;
            result.type_known = type_ok;
            pos_in            = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         fatal_ff     <= 1'b0;
         err_ff       <= lpfp_pkg::ERR_NONE;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            pos_ff       <= pos_in;
            fatal_ff     <= fatal_in;
            err_ff       <= err_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.payload.stream_byte;
      end
      if (advance) begin
         len_ff  <= len_in;
         type_ff <= type_in;
         id_ff   <= id_in;
         plen_ff <= plen_in;
         rem_ff  <= rem_in;
         out_ff  <= result;
      end
   end

endmodule

/* design/length_prefixed_frame_parser.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Deframes a byte stream of length/type/id-prefixed frames.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one stream byte per transaction. rsp_chan returns exactly
//   one result per byte: header byte absorbed, header complete (type, id,
//   payload length), payload byte, or fatal length error. frame_end marks the
//   result that closes a frame and carries type_known for it.
//   The csr_ port holds the maximum body length and the valid type range;
//   write it only while no bytes are in flight.
// Timing:
//   Two register stages (input byte, result); the header/payload state update
//   in lpfp_deframer is combinational between them. A result is registered
//   in the result stage after its byte has passed the input register. One
//   byte per cycle is sustained while rsp_chan is ready.
// Reset:
//   Synchronous reset clears the frame position, any latched fatal error and
//   the pipeline, and restores the register defaults.
// Backpressure:
//   When rsp_chan stalls, the result holds and one more byte can wait in the
//   input register; req_chan ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   lpfp_stream_if.sink                         req_chan,
   lpfp_stream_if.source                       rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lpfp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [lpfp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [lpfp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   lpfp_pkg::cfg_type cfg;

   lpfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lpfp_deframer u_deframer (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

/* design/lpfp_checker.sv */
// ----------------------------------------------------------------------------
// lpfp_checker
// Port-level assertions for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module lpfp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input lpfp_pkg::rsp_payload_type rsp_payload
);

   logic rsp_xfer;
   logic fatal_seen_ff;

   assign rsp_xfer = rsp_valid & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fatal_seen_ff <= 1'b0;
      end else if (rsp_xfer && rsp_payload.kind == lpfp_pkg::KIND_FATAL) begin
         fatal_seen_ff <= 1'b1;
      end
   end

   // nothing comes out right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a fatal error is sticky until reset
   a_fatal_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && fatal_seen_ff) |-> rsp_payload.kind == lpfp_pkg::KIND_FATAL)
      else $error("non-fatal result after fatal error");

   // error code is set exactly on fatal results
   a_error_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.kind == lpfp_pkg::KIND_FATAL) ==
                     (rsp_payload.error_code != lpfp_pkg::ERR_NONE)))
      else $error("error code does not match result kind");

   // type_known is only reported on the closing result
   a_type_known_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.frame_end) |-> !rsp_payload.type_known)
      else $error("type_known outside frame end");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("result changed while stalled");

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

/* tb/tb_length_prefixed_frame_parser.sv */
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_parser
// Self-checking bench for the length-prefixed frame parser. Byte streams of
// well-formed frames with random content go in through bursts and gaps, while
// the result side stalls on its own pattern. Every accepted byte is run
// through a local frame decoder, and each result is compared field by field.
// The register settings change between phases. A length error latches until
// reset, so that case is exercised last.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_parser;

   typedef enum {RX_STREAM, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [lpfp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [lpfp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [lpfp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                                csr_pready;

   lpfp_stream_if #(.payload_type(lpfp_pkg::req_payload_type)) req_if ();
   lpfp_stream_if #(.payload_type(lpfp_pkg::rsp_payload_type)) rsp_if ();

   length_prefixed_frame_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Register copies, as the block holds them
   logic [lpfp_pkg::MAX_BODY_WIDTH-1:0] max_body_cfg   = lpfp_pkg::MAX_BODY_RESET;
   logic [lpfp_pkg::TYPE_WIDTH-1:0]     type_first_cfg = lpfp_pkg::TYPE_FIRST_RESET;
   logic [lpfp_pkg::TYPE_WIDTH-1:0]     type_last_cfg  = lpfp_pkg::TYPE_LAST_RESET;

   // Decoder state
   logic [3:0]  hdr_pos    = '0;
   logic [31:0] len_acc    = '0;
   logic [15:0] type_acc   = '0;
   logic [31:0] id_acc     = '0;
   logic [20:0] pay_left   = '0;
   logic        fatal_seen = 1'b0;
   logic [1:0]  fatal_code = lpfp_pkg::ERR_NONE;

   lpfp_pkg::rsp_payload_type pending_results[$];
   int unsigned               mismatch_count = 0;
   int unsigned               bytes_sent     = 0;
   int unsigned               burst_left     = 0;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [31:0] body_ceiling();
      logic [31:0] m;
      m = 32'(max_body_cfg);
      if (lpfp_pkg::BODY_LIMIT < m) m = lpfp_pkg::BODY_LIMIT;
      if (m > lpfp_pkg::FIELD_BODY_CAP) m = lpfp_pkg::FIELD_BODY_CAP;
      return m;
   endfunction

   function automatic void close_frame(inout lpfp_pkg::rsp_payload_type r);
      r.frame_end  = 1'b1;
      r.type_known = (type_acc >= type_first_cfg) && (type_acc <= type_last_cfg);
      hdr_pos = '0;
      len_acc = '0;
   endfunction

   // Advances the decoder by one stream byte and returns the result it causes
   function automatic lpfp_pkg::rsp_payload_type deframe_byte(input logic [7:0] b);
      lpfp_pkg::rsp_payload_type r;
      logic [1:0]                code;
      logic [19:0]               plen;
      r = '0;
      if (fatal_seen) begin
         r.kind       = lpfp_pkg::KIND_FATAL;
         r.error_code = fatal_code;
         return r;
      end
      if (hdr_pos < 4) begin
         r.kind  = lpfp_pkg::KIND_HEADER_BYTE;
         len_acc = {len_acc[23:0], b};
         if (hdr_pos == 3) begin
            code = lpfp_pkg::ERR_NONE;
            if (len_acc < lpfp_pkg::MIN_BODY) code = lpfp_pkg::ERR_TOO_SHORT;
            else if (len_acc > body_ceiling()) code = lpfp_pkg::ERR_TOO_LONG;
            if (code != lpfp_pkg::ERR_NONE) begin
               fatal_seen   = 1'b1;
               fatal_code   = code;
               r.kind       = lpfp_pkg::KIND_FATAL;
               r.error_code = code;
               return r;
            end
         end
         hdr_pos = hdr_pos + 4'd1;
      end else if (hdr_pos < 6) begin
         r.kind   = lpfp_pkg::KIND_HEADER_BYTE;
         type_acc = {type_acc[7:0], b};
         hdr_pos  = hdr_pos + 4'd1;
      end else if (hdr_pos < 10) begin
         r.kind  = lpfp_pkg::KIND_HEADER_BYTE;
         id_acc  = {id_acc[23:0], b};
         hdr_pos = hdr_pos + 4'd1;
         if (hdr_pos == 10) begin
            plen             = 20'(len_acc - lpfp_pkg::MIN_BODY);
            r.kind           = lpfp_pkg::KIND_HEADER_DONE;
            r.message_type   = type_acc;
            r.message_id     = id_acc;
            r.payload_length = plen;
            pay_left         = {1'b0, plen};
            if (plen == 0) close_frame(r);
         end
      end else begin
         r.kind           = lpfp_pkg::KIND_PAYLOAD;
         r.message_type   = type_acc;
         r.message_id     = id_acc;
         r.payload_length = 20'(len_acc - lpfp_pkg::MIN_BODY);
         r.payload_data   = b;
         if (pay_left != 0) pay_left = pay_left - 21'd1;
         if (pay_left == 0) close_frame(r);
      end
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Predict on byte acceptance, check on result acceptance
   always @(posedge clock) begin : result_check
      lpfp_pkg::rsp_payload_type want;
      lpfp_pkg::rsp_payload_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            pending_results.push_back(deframe_byte(req_if.payload.stream_byte));
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual 0x%0h", $time, got);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(got.kind));
               check_field("message_type", 32'(want.message_type), 32'(got.message_type));
               check_field("message_id", want.message_id, got.message_id);
               check_field("payload_length", 32'(want.payload_length),
                           32'(got.payload_length));
               check_field("payload_data", 32'(want.payload_data), 32'(got.payload_data));
               check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
               check_field("type_known", 32'(want.type_known), 32'(got.type_known));
               check_field("error_code", 32'(want.error_code), 32'(got.error_code));
            end
         end
      end
   end

   // Result-side backpressure
   always @(posedge clock) begin : rx_stall
      static rx_mode_type rx_mode   = RX_STREAM;
      static int unsigned mode_left = 0;
      static int unsigned stall_left = 0;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (rx_mode)
            RX_STREAM: rsp_if.ready <= 1'b1;
            RX_LIGHT:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:  rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(1, 20);
                  rsp_if.ready <= 1'b0;
               end else begin
                  rsp_if.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // One byte per call; bursts of random length with random gaps between them
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      req_if.valid               <= 1'b1;
      req_if.payload.stream_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [31:0] frame_len, input logic [15:0] ftype,
                              input logic [31:0] fid);
      for (int i = 3; i >= 0; i--) send_byte(frame_len[8*i +: 8]);
      for (int i = 1; i >= 0; i--) send_byte(ftype[8*i +: 8]);
      for (int i = 3; i >= 0; i--) send_byte(fid[8*i +: 8]);
   endtask

   task automatic send_frame(input logic [31:0] frame_len, input logic [15:0] ftype,
                             input logic [31:0] fid);
      send_header(frame_len, ftype, fid);
      for (int unsigned i = 0; i < frame_len - lpfp_pkg::MIN_BODY; i++)
         send_byte(8'($urandom_range(0, 255)));
   endtask

   // Stop sending and let every outstanding result come back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      // let the last accepted byte be queued first
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         lpfp_pkg::REG_MAX_BODY_LENGTH:
            max_body_cfg = value[lpfp_pkg::MAX_BODY_WIDTH-1:0];
         lpfp_pkg::REG_VALID_TYPE_FIRST:
            type_first_cfg = value[lpfp_pkg::TYPE_WIDTH-1:0];
         lpfp_pkg::REG_VALID_TYPE_LAST:
            type_last_cfg = value[lpfp_pkg::TYPE_WIDTH-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_register(input logic [1:0] idx);
      logic [31:0] want;
      logic [31:0] got;
      case (idx)
         lpfp_pkg::REG_MAX_BODY_LENGTH:  want = 32'(max_body_cfg);
         lpfp_pkg::REG_VALID_TYPE_FIRST: want = 32'(type_first_cfg);
         default:                        want = 32'(type_last_cfg);
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      check_field("csr read", want, got);
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [20:0] mx, input logic [15:0] lo,
                                 input logic [15:0] hi);
      write_reg(lpfp_pkg::REG_MAX_BODY_LENGTH, 32'(mx));
      write_reg(lpfp_pkg::REG_VALID_TYPE_FIRST, 32'(lo));
      write_reg(lpfp_pkg::REG_VALID_TYPE_LAST, 32'(hi));
   endtask

   task automatic check_all_registers();
      check_register(lpfp_pkg::REG_MAX_BODY_LENGTH);
      check_register(lpfp_pkg::REG_VALID_TYPE_FIRST);
      check_register(lpfp_pkg::REG_VALID_TYPE_LAST);
   endtask

   task automatic test_reset_values();
      check_all_registers();
   endtask

   // Empty payload with an unknown type, then a one-byte payload at the top of
   // the valid range; all-zero and all-one bytes on the stream
   task automatic test_directed_frames();
      send_header(lpfp_pkg::MIN_BODY, 16'h0000, 32'hFFFF_FFFF);
      send_header(lpfp_pkg::MIN_BODY + 1, lpfp_pkg::TYPE_LAST_RESET, 32'h0000_0000);
      send_byte(8'hFF);
      drain_results();
   endtask

   task automatic test_register_access();
      write_settings(21'(lpfp_pkg::MIN_BODY), 16'hFFFF, 16'h0000);
      check_all_registers();
      write_settings(21'h1F_FFFF, 16'h0000, 16'hFFFF);
      check_all_registers();
   endtask

   task automatic test_length_boundary();
      write_reg(lpfp_pkg::REG_MAX_BODY_LENGTH, lpfp_pkg::MIN_BODY);
      send_frame(lpfp_pkg::MIN_BODY, 16'd1, $urandom);
      drain_results();
      write_reg(lpfp_pkg::REG_MAX_BODY_LENGTH, 32'd40);
      send_frame(32'd40, 16'd2, $urandom);
      send_frame(32'd39, 16'd3, $urandom);
      drain_results();
      write_reg(lpfp_pkg::REG_MAX_BODY_LENGTH, 32'h1F_FFFF);
      send_frame(lpfp_pkg::MIN_BODY + 5, 16'd4, $urandom);
      drain_results();
   endtask

   task automatic test_type_window();
      // first above last: nothing is known
      write_settings(21'd64, 16'd20, 16'd10);
      send_frame(lpfp_pkg::MIN_BODY + 2, 16'd15, $urandom);
      send_frame(lpfp_pkg::MIN_BODY, 16'd20, $urandom);
      drain_results();
      write_settings(21'd64, 16'hFFFF, 16'hFFFF);
      send_frame(lpfp_pkg::MIN_BODY + 1, 16'hFFFF, $urandom);
      send_frame(lpfp_pkg::MIN_BODY, 16'hFFFE, $urandom);
      drain_results();
      write_settings(21'd64, 16'h0000, 16'h0000);
      send_frame(lpfp_pkg::MIN_BODY + 1, 16'h0000, $urandom);
      send_frame(lpfp_pkg::MIN_BODY, 16'h0001, $urandom);
      drain_results();
   endtask

   task automatic pick_setting();
      logic [20:0] mx;
      logic [15:0] lo;
      logic [15:0] hi;
      case ($urandom_range(0, 4))
         0:       mx = 21'(lpfp_pkg::MIN_BODY);
         1:       mx = 21'h1F_FFFF;
         2:       mx = 21'(lpfp_pkg::BODY_LIMIT);
         3:       mx = 21'($urandom_range(7, 64));
         default: mx = 21'($urandom_range(65, 21'h1F_FFFF));
      endcase
      case ($urandom_range(0, 6))
         0: begin lo = 16'h0000; hi = 16'hFFFF; end
         1: begin lo = lpfp_pkg::TYPE_FIRST_RESET; hi = lpfp_pkg::TYPE_LAST_RESET; end
         2: begin lo = 16'($urandom); hi = 16'($urandom); end
         3: begin
            // empty range
            hi = 16'($urandom_range(0, 16'hFFFE));
            lo = 16'($urandom_range(32'(hi) + 1, 16'hFFFF));
         end
         4: begin lo = 16'($urandom); hi = lo; end
         5: begin lo = 16'hFFFF; hi = 16'hFFFF; end
         default: begin lo = 16'h0000; hi = 16'($urandom_range(0, 255)); end
      endcase
      write_settings(mx, lo, hi);
   endtask

   // Types cluster at the edges of the valid range
   function automatic logic [15:0] pick_type();
      case ($urandom_range(0, 5))
         0:       return type_first_cfg;
         1:       return type_last_cfg;
         2:       return type_first_cfg - 16'd1;
         3:       return type_last_cfg + 16'd1;
         4:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_payload_len();
      int unsigned room;
      int unsigned cap;
      room = body_ceiling() - lpfp_pkg::MIN_BODY;
      cap  = (room < 48) ? room : 48;
      if ($urandom_range(0, 3) == 0) return cap;
      return $urandom_range(0, (cap < 12) ? cap : 12);
   endfunction

   task automatic test_random_frames();
      int unsigned frames_left;
      frames_left = 0;
      while (bytes_sent < 1020) begin
         if (frames_left == 0) begin
            drain_results();
            pick_setting();
            frames_left = $urandom_range(4, 12);
         end
         send_frame(lpfp_pkg::MIN_BODY + pick_payload_len(), pick_type(), $urandom);
         frames_left--;
      end
      drain_results();
   endtask

   // The error latches until reset, so only one flavor is reachable per run
   task automatic test_fatal_length();
      logic [31:0] frame_len;
      case ($urandom_range(0, 3))
         0: begin
            write_reg(lpfp_pkg::REG_MAX_BODY_LENGTH, $urandom_range(6, 200));
            frame_len = $urandom_range(0, lpfp_pkg::MIN_BODY - 1);
         end
         1: begin
            write_reg(lpfp_pkg::REG_MAX_BODY_LENGTH, $urandom_range(6, 200));
            frame_len = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                      : 32'(max_body_cfg) + 32'd1 + $urandom_range(0, 1000);
         end
         2: begin
            // register above the hard ceiling
            write_reg(lpfp_pkg::REG_MAX_BODY_LENGTH, 32'h1F_FFFF);
            frame_len = lpfp_pkg::BODY_LIMIT + 1 + $urandom_range(0, 3);
         end
         default: begin
            // maximum below six: any legal-looking length is too long
            write_reg(lpfp_pkg::REG_MAX_BODY_LENGTH,
                      $urandom_range(0, lpfp_pkg::MIN_BODY - 1));
            frame_len = lpfp_pkg::MIN_BODY + $urandom_range(0, 20);
         end
      endcase
      send_header(frame_len, pick_type(), $urandom);
      repeat (24) send_byte(8'($urandom_range(0, 255)));
      drain_results();
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_directed_frames();
      test_register_access();
      test_length_boundary();
      test_type_window();
      test_random_frames();
      test_fatal_length();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
